### design/dtok_pkg.sv
// Shared types and constants for the delimited text field tokenizer.
// Holds the character codes, token kinds, parser states and the step result struct.
// Depends on nothing; every other design file refers to it by scoped names.
package dtok_pkg;

   // Character codes the parser reacts to
   localparam logic [7:0] CharTab       = 8'h09;
   localparam logic [7:0] CharLf        = 8'h0A;
   localparam logic [7:0] CharCr        = 8'h0D;
   localparam logic [7:0] CharQuote     = 8'h22;
   localparam logic [7:0] CharComma     = 8'h2C;
   localparam logic [7:0] CharColon     = 8'h3A;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharLowerN    = 8'h6E;
   localparam logic [7:0] CharLowerT    = 8'h74;

   // Configuration register layout
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 2;
   localparam logic [CsrAddrWidth-1:0] AddrDelimSelect = 2'd0;

   // Field separator codes; the fourth code selects no separator
   typedef enum logic [1:0] {
      DELIM_TAB   = 2'd0,
      DELIM_COLON = 2'd1,
      DELIM_COMMA = 2'd2
   } delim_type;

   // Token kinds on the result channel
   typedef enum logic [1:0] {
      KIND_CHAR   = 2'd0,
      KIND_FIELD  = 2'd1,
      KIND_RECORD = 2'd2,
      KIND_DROP   = 2'd3
   } kind_type;

   // Parser states, one-hot
   typedef enum logic [5:0] {
      ST_BEGIN      = 6'b000001,
      ST_PLAIN      = 6'b000010,
      ST_PLAIN_ESC  = 6'b000100,
      ST_QUOTED     = 6'b001000,
      ST_QUOTED_ESC = 6'b010000,
      ST_QUOTE_SEEN = 6'b100000
   } state_type;

   // Outcome of one parser step
   typedef struct packed {
      state_type  next_state;
      logic [7:0] next_fields;
      logic       emit;
      kind_type   kind;
      logic [7:0] char_out;
      logic [7:0] field_number;
   } step_type;

endpackage

### design/delimited_text_field_tokenizer.sv
// Top level of the delimited text field tokenizer.
// Depends on dtok_pkg, dtok_csr and dtok_decode.
//
// Usage:
//   The req_ channel carries one transaction per byte (req_char_in) or an end-of-file
//   mark (req_end_of_file). The rsp_ channel carries zero or one token per request:
//   rsp_kind (payload char, field end, field and record end, record end dropping the
//   open field), rsp_char_out and the saturating rsp_field_number.
//   The separator (tab, colon, comma) is written through the APB-style port at
//   address 0; the user must write it only while the block is idle (not enforced).
// Path: an accepted request is held in the input register; its token is loaded from
//   there into the result register once that register is free, and presented from it.
// Throughput: one request per cycle while the result is not stalled. The parser state
//   and field count update as each item leaves the input register, so the next byte
//   can follow directly behind.
// Stall: a stalled result holds in the result register; the input register keeps
//   accepting until it is full and the result register is blocked, and req_ready
//   then drops until the receiver takes the token.
// Reset: synchronous, active high; clears both valid flags, returns the parser to
//   begin of record with zero fields and the separator to tab.
module delimited_text_field_tokenizer #(
   parameter int unsigned FIELD_COUNT_MAX = 255
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_char_in,
   input  logic                                 req_end_of_file,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_kind,
   output logic [7:0]                           rsp_char_out,
   output logic [7:0]                           rsp_field_number,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dtok_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [dtok_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [dtok_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                 pready
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_char_ff, in_char_in;
   logic                in_eof_ff, in_eof_in;
   dtok_pkg::state_type state_ff, state_in;
   logic [7:0]          fields_ff, fields_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic [7:0]          rsp_num_ff, rsp_num_in;
   logic [1:0]          delim_select;
   logic                out_free;
   logic                advance;
   logic                req_take;
   dtok_pkg::step_type  step;

   dtok_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .delim_select (delim_select)
   );

   dtok_decode #(
      .FIELD_COUNT_MAX (FIELD_COUNT_MAX)
   ) u_decode (
      .state        (state_ff),
      .fields_done  (fields_ff),
      .char_in      (in_char_ff),
      .end_of_file  (in_eof_ff),
      .delim_select (delim_select),
      .step         (step)
   );

   // Handshake: the input register moves whenever the result register can load
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_eof_in   = in_eof_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (req_take) begin
         in_char_in = req_char_in;
         in_eof_in  = req_end_of_file;
      end
   end

   // Parser state advances with each item leaving the input register
   always_comb begin
      state_in  = state_ff;
      fields_in = fields_ff;
      if (advance) begin
         state_in  = step.next_state;
         fields_in = step.next_fields;
      end
   end

   // Result register: load a token, drop the valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_num_in   = rsp_num_ff;
      if (out_free) begin
         rsp_valid_in = advance && step.emit;
      end
      if (advance && step.emit) begin
         rsp_kind_in = step.kind;
         rsp_char_in = step.char_out;
         rsp_num_in  = step.field_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= dtok_pkg::ST_BEGIN;
         fields_ff    <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         fields_ff    <= fields_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      in_eof_ff   <= in_eof_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_num_ff  <= rsp_num_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_char_out     = rsp_char_ff;
   assign rsp_field_number = rsp_num_ff;

endmodule

### design/dtok_csr.sv
// APB-style configuration register for the tokenizer: the field separator select.
// Depends on dtok_pkg for the address layout and the separator codes.
module dtok_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dtok_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [dtok_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [dtok_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                 pready,
   output logic [1:0]                           delim_select
);

   logic [1:0] delim_ff;
   logic [1:0] delim_in;
   logic       write_en;

   // Complete a write in the access phase; byte offset bits do not select a register
   assign write_en = psel && penable && pwrite;

   always_comb begin
      delim_in = delim_ff;
      if (write_en) begin
         delim_in = pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= dtok_pkg::DELIM_TAB;
      end else begin
         delim_ff <= delim_in;
      end
   end

   // Return the register on an aligned read, zero elsewhere
   assign prdata = (paddr == dtok_pkg::AddrDelimSelect)
                   ? {{(dtok_pkg::CsrDataWidth-2){1'b0}}, delim_ff}
                   : '0;
   assign pready       = 1'b1;
   assign delim_select = delim_ff;

endmodule

### design/dtok_decode.sv
// Single-step parser decision: from the current state, field count and one byte,
// derive the next state, the next field count and the token, if any.
// Depends on dtok_pkg for character codes, states, kinds and the step struct.
module dtok_decode #(
   parameter int unsigned FIELD_COUNT_MAX = 255
) (
   input  dtok_pkg::state_type state,
   input  logic [7:0]          fields_done,
   input  logic [7:0]          char_in,
   input  logic                end_of_file,
   input  logic [1:0]          delim_select,
   output dtok_pkg::step_type  step
);

   localparam logic [7:0] CountCap = (FIELD_COUNT_MAX > 255) ? 8'd255 : 8'(FIELD_COUNT_MAX);

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_CHAR   = 3'd1,
      ACT_PLAIN  = 3'd2,
      ACT_RECORD = 3'd3,
      ACT_DROP   = 3'd4
   } action_type;

   action_type          action;
   dtok_pkg::state_type nxt_state;
   logic [7:0]          fields_inc;
   logic [7:0]          esc_char;
   logic [7:0]          act_char;
   logic                is_delim;
   logic                is_end;

   // Saturating count of the field in progress
   assign fields_inc = (fields_done >= CountCap) ? CountCap : fields_done + 8'd1;

   // Map escape letters n and t
   assign esc_char = (char_in == dtok_pkg::CharLowerN) ? dtok_pkg::CharLf :
                     (char_in == dtok_pkg::CharLowerT) ? dtok_pkg::CharTab : char_in;

   assign is_end = end_of_file || (char_in == dtok_pkg::CharLf);

   // Match the selected separator
   always_comb begin
      case (delim_select)
         dtok_pkg::DELIM_TAB:   is_delim = (char_in == dtok_pkg::CharTab);
         dtok_pkg::DELIM_COLON: is_delim = (char_in == dtok_pkg::CharColon);
         dtok_pkg::DELIM_COMMA: is_delim = (char_in == dtok_pkg::CharComma);
         default:               is_delim = 1'b0;
      endcase
   end

   // Pick the action and state move for this byte
   always_comb begin
      action    = ACT_NONE;
      act_char  = char_in;
      nxt_state = state;
      case (state)
         dtok_pkg::ST_PLAIN: begin
            if (is_end) begin
               action = ACT_RECORD;
            end else if (char_in == dtok_pkg::CharBackslash) begin
               nxt_state = dtok_pkg::ST_PLAIN_ESC;
            end else if (char_in == dtok_pkg::CharQuote) begin
               nxt_state = dtok_pkg::ST_QUOTED;
            end else if (char_in != dtok_pkg::CharCr) begin
               action = ACT_PLAIN;
            end
         end
         dtok_pkg::ST_PLAIN_ESC: begin
            if (end_of_file) begin
               action = ACT_DROP;
            end else if (char_in != dtok_pkg::CharCr) begin
               nxt_state = dtok_pkg::ST_PLAIN;
               action    = ACT_CHAR;
               act_char  = esc_char;
            end
         end
         dtok_pkg::ST_QUOTED: begin
            if (end_of_file) begin
               action = ACT_RECORD;
            end else if (char_in == dtok_pkg::CharBackslash) begin
               nxt_state = dtok_pkg::ST_QUOTED_ESC;
            end else if (char_in == dtok_pkg::CharQuote) begin
               nxt_state = dtok_pkg::ST_QUOTE_SEEN;
            end else if (char_in != dtok_pkg::CharCr) begin
               action = ACT_CHAR;
            end
         end
         dtok_pkg::ST_QUOTED_ESC: begin
            if (end_of_file) begin
               action = ACT_RECORD;
            end else if (char_in != dtok_pkg::CharCr) begin
               nxt_state = dtok_pkg::ST_QUOTED;
               action    = ACT_CHAR;
               act_char  = esc_char;
            end
         end
         dtok_pkg::ST_QUOTE_SEEN: begin
            if (is_end) begin
               action = ACT_RECORD;
            end else if (char_in == dtok_pkg::CharQuote) begin
               // doubled quote gives a literal quote
               nxt_state = dtok_pkg::ST_QUOTED;
               action    = ACT_CHAR;
               act_char  = dtok_pkg::CharQuote;
            end else if (char_in == dtok_pkg::CharCr) begin
               nxt_state = dtok_pkg::ST_PLAIN;
            end else begin
               action = ACT_PLAIN;
            end
         end
         default: begin
            // begin of record
            if (is_end) begin
               action = ACT_DROP;
            end else if (char_in == dtok_pkg::CharBackslash) begin
               nxt_state = dtok_pkg::ST_PLAIN_ESC;
            end else if (char_in == dtok_pkg::CharQuote) begin
               nxt_state = dtok_pkg::ST_QUOTED;
            end else if (char_in == dtok_pkg::CharCr) begin
               nxt_state = dtok_pkg::ST_PLAIN;
            end else begin
               action = ACT_PLAIN;
            end
         end
      endcase
   end

   // Turn the action into a token and the updated count
   always_comb begin
      step.next_state   = nxt_state;
      step.next_fields  = fields_done;
      step.emit         = 1'b0;
      step.kind         = dtok_pkg::KIND_CHAR;
      step.char_out     = 8'd0;
      step.field_number = fields_inc;
      case (action)
         ACT_CHAR: begin
            step.emit     = 1'b1;
            step.char_out = act_char;
         end
         ACT_PLAIN: begin
            step.next_state = dtok_pkg::ST_PLAIN;
            step.emit       = 1'b1;
            if (is_delim) begin
               step.next_fields = fields_inc;
               step.kind        = dtok_pkg::KIND_FIELD;
            end else begin
               step.char_out = char_in;
            end
         end
         ACT_RECORD: begin
            step.next_state  = dtok_pkg::ST_BEGIN;
            step.next_fields = 8'd0;
            step.emit        = 1'b1;
            step.kind        = dtok_pkg::KIND_RECORD;
         end
         ACT_DROP: begin
            step.next_state   = dtok_pkg::ST_BEGIN;
            step.next_fields  = 8'd0;
            step.emit         = 1'b1;
            step.kind         = dtok_pkg::KIND_DROP;
            step.field_number = fields_done;
         end
         default: begin
            step.emit = 1'b0;
         end
      endcase
   end

endmodule

### design/dtok_checker.sv
// Port-level checks for the delimited text field tokenizer, bound to the top level.
// Depends on dtok_pkg for token kinds and the register layout.
module dtok_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [7:0]                           req_char_in,
   input logic                                 req_end_of_file,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [1:0]                           rsp_kind,
   input logic [7:0]                           rsp_char_out,
   input logic [7:0]                           rsp_field_number,
   input logic                                 psel,
   input logic                                 penable,
   input logic                                 pwrite,
   input logic [dtok_pkg::CsrAddrWidth-1:0]    paddr,
   input logic [dtok_pkg::CsrDataWidth-1:0]    pwdata,
   input logic [dtok_pkg::CsrDataWidth-1:0]    prdata,
   input logic                                 pready
);

   // Hold a stalled token
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_char_out) && $stable(rsp_field_number))
      else $error("stalled token changed");

   // Only payload tokens carry a character
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != dtok_pkg::KIND_CHAR) |-> rsp_char_out == 8'd0)
      else $error("non-payload token carries a character");

   // Payload and field ends always name a field from one upward
   a_field_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != dtok_pkg::KIND_DROP) |-> rsp_field_number != 8'd0)
      else $error("field number zero on a field token");

   // A separator write reads back on the next cycle
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && (paddr == dtok_pkg::AddrDelimSelect)
      |=> prdata[1:0] == $past(pwdata[1:0]))
      else $error("separator register did not take the written value");

   // No token out of an empty pipe right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && req_ready)
      else $error("result pending right after reset");

endmodule

bind delimited_text_field_tokenizer dtok_checker u_dtok_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the delimited text field tokenizer.
// Tracks the parser state in a local predictor and checks every token; needs dtok_pkg
// and the delimited_text_field_tokenizer top level.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [7:0]  CountCap    = 8'd255;
   localparam int unsigned DrainCycles = 4;
   localparam int unsigned CycleLimit  = 600000;

   typedef struct packed {
      dtok_pkg::kind_type kind;
      logic [7:0]         char_out;
      logic [7:0]         field_number;
   } token_type;

   logic clock = 1'b0;
   logic reset;

   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_in;
   logic       req_end_of_file;

   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_char_out;
   logic [7:0] rsp_field_number;

   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [dtok_pkg::CsrAddrWidth-1:0] paddr;
   logic [dtok_pkg::CsrDataWidth-1:0] pwdata;
   logic [dtok_pkg::CsrDataWidth-1:0] prdata;
   logic                              pready;

   // Predictor copy of the parser, its field count and the separator register
   dtok_pkg::state_type parse_st;
   logic [7:0]          field_cnt;
   logic [1:0]          sep_sel;

   token_type   pending_tokens[$];
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned tokens_seen;
   bit          no_idle;

   delimited_text_field_tokenizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_char_out     (rsp_char_out),
      .rsp_field_number (rsp_field_number),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] next_count(input logic [7:0] v);
      return (v >= CountCap) ? CountCap : v + 8'd1;
   endfunction

   function automatic bit is_separator(input logic [7:0] c);
      case (sep_sel)
         dtok_pkg::DELIM_TAB:   return c == dtok_pkg::CharTab;
         dtok_pkg::DELIM_COLON: return c == dtok_pkg::CharColon;
         dtok_pkg::DELIM_COMMA: return c == dtok_pkg::CharComma;
         default:               return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] c);
      if (c == dtok_pkg::CharLowerN) return dtok_pkg::CharLf;
      if (c == dtok_pkg::CharLowerT) return dtok_pkg::CharTab;
      return c;
   endfunction

   function automatic token_type payload(input logic [7:0] c);
      token_type tok;
      tok.kind         = dtok_pkg::KIND_CHAR;
      tok.char_out     = c;
      tok.field_number = next_count(field_cnt);
      return tok;
   endfunction

   function automatic token_type close_record(input bit with_field);
      token_type tok;
      tok.char_out = 8'h00;
      if (with_field) begin
         tok.kind         = dtok_pkg::KIND_RECORD;
         tok.field_number = next_count(field_cnt);
      end else begin
         tok.kind         = dtok_pkg::KIND_DROP;
         tok.field_number = field_cnt;
      end
      parse_st  = dtok_pkg::ST_BEGIN;
      field_cnt = 8'd0;
      return tok;
   endfunction

   // Unquoted byte: a separator closes the field, anything else is payload
   function automatic token_type unquoted_byte(input logic [7:0] c);
      token_type tok;
      parse_st = dtok_pkg::ST_PLAIN;
      if (is_separator(c)) begin
         field_cnt        = next_count(field_cnt);
         tok.kind         = dtok_pkg::KIND_FIELD;
         tok.char_out     = 8'h00;
         tok.field_number = field_cnt;
         return tok;
      end
      return payload(c);
   endfunction

   // Advance the parser by one transaction; return 1 when it yields a token
   function automatic bit tokenize_byte(input logic [7:0] c, input logic eof,
                                        output token_type tok);
      tok = '0;
      case (parse_st)
         dtok_pkg::ST_PLAIN: begin
            if (eof || c == dtok_pkg::CharLf) begin
               tok = close_record(1'b1);
               return 1'b1;
            end
            if (c == dtok_pkg::CharBackslash) begin
               parse_st = dtok_pkg::ST_PLAIN_ESC;
               return 1'b0;
            end
            if (c == dtok_pkg::CharQuote) begin
               parse_st = dtok_pkg::ST_QUOTED;
               return 1'b0;
            end
            if (c == dtok_pkg::CharCr) return 1'b0;
            tok = unquoted_byte(c);
            return 1'b1;
         end
         dtok_pkg::ST_PLAIN_ESC: begin
            if (eof) begin
               tok = close_record(1'b0);
               return 1'b1;
            end
            if (c == dtok_pkg::CharCr) return 1'b0;
            parse_st = dtok_pkg::ST_PLAIN;
            tok = payload(unescape(c));
            return 1'b1;
         end
         dtok_pkg::ST_QUOTED: begin
            if (eof) begin
               tok = close_record(1'b1);
               return 1'b1;
            end
            if (c == dtok_pkg::CharBackslash) begin
               parse_st = dtok_pkg::ST_QUOTED_ESC;
               return 1'b0;
            end
            if (c == dtok_pkg::CharQuote) begin
               parse_st = dtok_pkg::ST_QUOTE_SEEN;
               return 1'b0;
            end
            if (c == dtok_pkg::CharCr) return 1'b0;
            tok = payload(c);
            return 1'b1;
         end
         dtok_pkg::ST_QUOTED_ESC: begin
            if (eof) begin
               tok = close_record(1'b1);
               return 1'b1;
            end
            if (c == dtok_pkg::CharCr) return 1'b0;
            parse_st = dtok_pkg::ST_QUOTED;
            tok = payload(unescape(c));
            return 1'b1;
         end
         dtok_pkg::ST_QUOTE_SEEN: begin
            if (eof || c == dtok_pkg::CharLf) begin
               tok = close_record(1'b1);
               return 1'b1;
            end
            if (c == dtok_pkg::CharQuote) begin
               parse_st = dtok_pkg::ST_QUOTED;
               tok = payload(dtok_pkg::CharQuote);
               return 1'b1;
            end
            if (c == dtok_pkg::CharCr) begin
               parse_st = dtok_pkg::ST_PLAIN;
               return 1'b0;
            end
            tok = unquoted_byte(c);
            return 1'b1;
         end
         default: begin
            if (eof || c == dtok_pkg::CharLf) begin
               tok = close_record(1'b0);
               return 1'b1;
            end
            if (c == dtok_pkg::CharBackslash) begin
               parse_st = dtok_pkg::ST_PLAIN_ESC;
               return 1'b0;
            end
            if (c == dtok_pkg::CharQuote) begin
               parse_st = dtok_pkg::ST_QUOTED;
               return 1'b0;
            end
            if (c == dtok_pkg::CharCr) begin
               parse_st = dtok_pkg::ST_PLAIN;
               return 1'b0;
            end
            tok = unquoted_byte(c);
            return 1'b1;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- helpers

   task automatic report_error(input string msg);
      error_count++;
      $display("mismatch: %s", msg);
   endtask

   // Send one transaction after a gap, random unless no_idle, then predict its token
   task automatic send_item(input logic [7:0] c, input logic eof);
      int unsigned gap;
      token_type tok;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_in     <= c;
      req_end_of_file <= eof;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
      if (tokenize_byte(c, eof, tok)) pending_tokens.push_back(tok);
   endtask

   task automatic send_eof();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Hold the sender until every token has come and the pipe is empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] sel);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= dtok_pkg::AddrDelimSelect;
      pwdata  <= {30'd0, sel};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sep_sel = sel;
      // return to idle before the next transfer
      @(posedge clock);
   endtask

   task automatic csr_read_check();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= dtok_pkg::AddrDelimSelect;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== {30'd0, sep_sel})
         report_error($sformatf("separator register reads %08h, want %0d", prdata, sep_sel));
      psel    <= 1'b0;
      penable <= 1'b0;
      // return to idle before the next transfer
      @(posedge clock);
   endtask

   // The active separator; with no separator selected, any of the three
   function automatic logic [7:0] separator_byte();
      case (sep_sel)
         dtok_pkg::DELIM_TAB:   return dtok_pkg::CharTab;
         dtok_pkg::DELIM_COLON: return dtok_pkg::CharColon;
         dtok_pkg::DELIM_COMMA: return dtok_pkg::CharComma;
         default: begin
            case ($urandom_range(0, 2))
               0:       return dtok_pkg::CharTab;
               1:       return dtok_pkg::CharColon;
               default: return dtok_pkg::CharComma;
            endcase
         end
      endcase
   endfunction

   // Field content, weighted toward the bytes the parser reacts to
   function automatic logic [7:0] content_byte();
      case ($urandom_range(0, 17))
         0:       return dtok_pkg::CharTab;
         1:       return dtok_pkg::CharColon;
         2:       return dtok_pkg::CharComma;
         3:       return dtok_pkg::CharCr;
         4:       return dtok_pkg::CharLf;
         5:       return dtok_pkg::CharQuote;
         6:       return dtok_pkg::CharBackslash;
         7:       return dtok_pkg::CharLowerN;
         8:       return dtok_pkg::CharLowerT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One well-formed record with random content and a random terminator
   task automatic send_record(input int unsigned nfields);
      int unsigned len;
      bit quoted;
      logic [7:0] b;
      for (int unsigned f = 0; f < nfields; f++) begin
         if (f != 0) send_item(separator_byte(), 1'b0);
         quoted = ($urandom_range(0, 2) == 0);
         if (quoted) send_item(dtok_pkg::CharQuote, 1'b0);
         len = $urandom_range(0, 6);
         for (int unsigned k = 0; k < len; k++) begin
            b = content_byte();
            if (quoted) begin
               // double a quote; pair a backslash with the byte it escapes
               if (b == dtok_pkg::CharQuote) send_item(dtok_pkg::CharQuote, 1'b0);
               if (b == dtok_pkg::CharBackslash) begin
                  send_item(dtok_pkg::CharBackslash, 1'b0);
                  b = content_byte();
               end
            end else if (b == dtok_pkg::CharQuote || b == dtok_pkg::CharBackslash ||
                         b == dtok_pkg::CharLf || is_separator(b) ||
                         $urandom_range(0, 7) == 0) begin
               send_item(dtok_pkg::CharBackslash, 1'b0);
            end
            send_item(b, 1'b0);
         end
         if (quoted) begin
            send_item(dtok_pkg::CharQuote, 1'b0);
            if ($urandom_range(0, 7) == 0) send_item(dtok_pkg::CharCr, 1'b0);
         end
      end
      case ($urandom_range(0, 9))
         0: send_eof();
         1: begin
            send_item(dtok_pkg::CharCr, 1'b0);
            send_item(dtok_pkg::CharLf, 1'b0);
         end
         2: begin
            send_item(dtok_pkg::CharBackslash, 1'b0);
            send_eof();
         end
         default: send_item(dtok_pkg::CharLf, 1'b0);
      endcase
   endtask

   // Unstructured bytes and end-of-file marks, then a newline
   task automatic send_noise();
      int unsigned len;
      len = $urandom_range(1, 12);
      for (int unsigned k = 0; k < len; k++) begin
         if ($urandom_range(0, 11) == 0) send_eof();
         else if ($urandom_range(0, 1) == 0) send_item(content_byte(), 1'b0);
         else send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      send_item(dtok_pkg::CharLf, 1'b0);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_register_reset();
      csr_read_check();
   endtask

   task automatic test_directed();
      wait_drained();
      csr_write(dtok_pkg::DELIM_COMMA);
      csr_read_check();
      // empty line, then end of file at begin of record
      send_item(dtok_pkg::CharLf, 1'b0);
      send_item(8'hA5, 1'b1);
      // byte extremes in two fields, CRLF ending
      send_item(8'h00, 1'b0);
      send_item(dtok_pkg::CharComma, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(dtok_pkg::CharCr, 1'b0);
      send_item(dtok_pkg::CharLf, 1'b0);
      // quoted separator, doubled quote, a byte after the closing quote
      send_item(dtok_pkg::CharQuote, 1'b0);
      send_item(dtok_pkg::CharComma, 1'b0);
      send_item(dtok_pkg::CharQuote, 1'b0);
      send_item(dtok_pkg::CharQuote, 1'b0);
      send_item(dtok_pkg::CharQuote, 1'b0);
      send_item("x", 1'b0);
      send_item(dtok_pkg::CharLf, 1'b0);
      // CR after a closing quote leaves the quotes
      send_item(dtok_pkg::CharQuote, 1'b0);
      send_item(dtok_pkg::CharQuote, 1'b0);
      send_item(dtok_pkg::CharCr, 1'b0);
      send_item(dtok_pkg::CharComma, 1'b0);
      send_eof();
      // escapes: \n, \t, CR keeps the escape pending, escaped separator
      send_item(dtok_pkg::CharBackslash, 1'b0);
      send_item(dtok_pkg::CharLowerN, 1'b0);
      send_item(dtok_pkg::CharBackslash, 1'b0);
      send_item(dtok_pkg::CharLowerT, 1'b0);
      send_item(dtok_pkg::CharBackslash, 1'b0);
      send_item(dtok_pkg::CharCr, 1'b0);
      send_item(dtok_pkg::CharComma, 1'b0);
      // end of file after a backslash drops the open field
      send_item(dtok_pkg::CharBackslash, 1'b0);
      send_eof();
      // end of file inside quotes, after an escape
      send_item(dtok_pkg::CharQuote, 1'b0);
      send_item(dtok_pkg::CharBackslash, 1'b0);
      send_eof();
      // bytes after end of file start a new record
      send_item("k", 1'b0);
      send_eof();
   endtask

   task automatic test_field_saturation();
      wait_drained();
      csr_write(dtok_pkg::DELIM_COLON);
      csr_read_check();
      send_item("a", 1'b0);
      for (int k = 0; k < 259; k++) begin
         no_idle = (k % 64) < 48;
         send_item(dtok_pkg::CharColon, 1'b0);
      end
      no_idle = 1'b0;
      send_item("b", 1'b0);
      send_item(dtok_pkg::CharLf, 1'b0);
   endtask

   task automatic test_random_text(input logic [1:0] sel, input int unsigned count);
      int unsigned stop_at;
      wait_drained();
      csr_write(sel);
      csr_read_check();
      stop_at = items_sent + count;
      send_record(3);
      // pause the sender until every token is back
      wait_drained();
      while (items_sent < stop_at) begin
         no_idle = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 7) == 0) send_noise();
         else send_record($urandom_range(0, 6));
         if ($urandom_range(0, 15) == 0) wait_drained();
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- result side

   // Stall the receiver at random and check each token against the oldest expectation
   initial begin : result_sink
      int unsigned stall;
      token_type want;
      rsp_ready <= 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            tokens_seen++;
            if (pending_tokens.size() == 0) begin
               report_error($sformatf("token %0d unexpected: kind %0d char %02h field %0d",
                                      tokens_seen, rsp_kind, rsp_char_out,
                                      rsp_field_number));
            end else begin
               want = pending_tokens.pop_front();
               if (rsp_kind !== want.kind)
                  report_error($sformatf("token %0d kind %0d, want %0d",
                                         tokens_seen, rsp_kind, want.kind));
               if (rsp_char_out !== want.char_out)
                  report_error($sformatf("token %0d char %02h, want %02h",
                                         tokens_seen, rsp_char_out, want.char_out));
               if (rsp_field_number !== want.field_number)
                  report_error($sformatf("token %0d field number %0d, want %0d",
                                         tokens_seen, rsp_field_number,
                                         want.field_number));
            end
            stall = no_idle ? 0 : $urandom_range(0, 16);
         end
         if (stall != 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // End the run if it hangs
   initial begin : watchdog
      repeat (CycleLimit) @(posedge clock);
      $display("[delimited_text_field_tokenizer] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_char_in     <= 8'h00;
      req_end_of_file <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      parse_st    = dtok_pkg::ST_BEGIN;
      field_cnt   = 8'd0;
      sep_sel     = 2'd0;
      error_count = 0;
      items_sent  = 0;
      tokens_seen = 0;
      no_idle     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_reset();
      test_directed();
      test_field_saturation();
      test_random_text(dtok_pkg::DELIM_COMMA, 280);
      test_random_text(dtok_pkg::DELIM_TAB, 260);
      test_random_text(dtok_pkg::DELIM_COLON, 260);
      test_random_text(2'd3, 180);
      wait_drained();

      if (error_count == 0) begin
         $display("[delimited_text_field_tokenizer] OK");
      end else begin
         $display("[delimited_text_field_tokenizer] ERROR");
      end
      $finish;
   end

endmodule

### delimited_text_field_tokenizer.f
design/dtok_pkg.sv
design/dtok_csr.sv
design/dtok_decode.sv
design/delimited_text_field_tokenizer.sv
design/dtok_checker.sv
tb/tb_top.sv
